// ===== rtl/ism_pkg.sv =====
// ism_pkg: shared types and constants of the integer stack machine step block
// no dependencies; used by the interfaces, the divider and the top level
`default_nettype none

package ism_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int MEM_DEPTH   = 1024;
    localparam int RET_DEPTH   = 64;
    localparam int PROG_DEPTH  = 4096;

    localparam int DATA_W  = 32;
    localparam int STK_AW  = $clog2(STACK_DEPTH);
    localparam int SP_W    = $clog2(STACK_DEPTH + 1);
    localparam int MEM_AW  = $clog2(MEM_DEPTH);
    localparam int RET_AW  = $clog2(RET_DEPTH);
    localparam int RSP_W   = $clog2(RET_DEPTH + 1);
    localparam int PROG_AW = $clog2(PROG_DEPTH);
    localparam int PC_W    = PROG_AW + 1;

    typedef enum logic [4:0] {
        OP_NOP    = 5'd0,
        OP_PUSH   = 5'd1,
        OP_PRINT  = 5'd2,
        OP_DECL   = 5'd3,
        OP_STORE  = 5'd4,
        OP_STOREX = 5'd5,
        OP_LOAD   = 5'd6,
        OP_LOADX  = 5'd7,
        OP_INPUT  = 5'd8,
        OP_CMP    = 5'd9,
        OP_ADD    = 5'd10,
        OP_SUB    = 5'd11,
        OP_MUL    = 5'd12,
        OP_DIV    = 5'd13,
        OP_MOD    = 5'd14,
        OP_POP    = 5'd15,
        OP_JMP    = 5'd16,
        OP_JE     = 5'd17,
        OP_JNE    = 5'd18,
        OP_JG     = 5'd19,
        OP_JL     = 5'd20,
        OP_JGE    = 5'd21,
        OP_JLE    = 5'd22,
        OP_CALL   = 5'd23,
        OP_RET    = 5'd24,
        OP_EXIT   = 5'd25
    } op_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_UNDERFLOW = 3'd1,
        ERR_OVERFLOW  = 3'd2,
        ERR_DIV_ZERO  = 3'd3,
        ERR_BAD_ADDR  = 3'd4,
        ERR_BAD_OP    = 3'd5
    } err_t;

    typedef enum logic [1:0] {
        CMP_EQ = 2'd0,
        CMP_GT = 2'd1,
        CMP_LT = 2'd2
    } cmp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ1,
        ST_READ2,
        ST_EXEC,
        ST_DIV,
        ST_WB
    } state_t;

    typedef struct packed {
        logic              start;
        logic              is_mod;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/ism_if.sv =====
// ism_in_if, ism_out_if: valid/ready channels for instructions and step results
// depends on ism_pkg
`default_nettype none

interface ism_in_if;
    import ism_pkg::*;
    logic              valid;
    logic              ready;
    logic [4:0]        mode;
    logic [31:0]       arg;
    logic [9:0]        index_address;
    logic [31:0]       input_value;

    modport source (output valid, mode, arg, index_address, input_value, input ready);
    modport sink   (input valid, mode, arg, index_address, input_value, output ready);
endinterface

interface ism_out_if;
    import ism_pkg::*;
    logic              valid;
    logic              ready;
    logic [12:0]       next_pc;
    logic              print_valid;
    logic [31:0]       print_value;
    logic              halted;
    logic [2:0]        error;

    modport source (output valid, next_pc, print_valid, print_value, halted, error,
                    input ready);
    modport sink   (input valid, next_pc, print_valid, print_value, halted, error,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/ism_div.sv =====
// ism_div: signed 32-bit divider, one restoring step per cycle
// depends on ism_pkg; gives truncated quotient or remainder
`default_nettype none

module ism_div
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ism_pkg::div_req_t req,
    output ism_pkg::div_rsp_t      rsp
);
    import ism_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] dvs_reg;
    logic              neg_q_reg;
    logic              neg_r_reg;
    logic              is_mod_reg;
    logic              done_reg;

    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   shifted;
    logic [DATA_W-1:0] mag_a;
    logic [DATA_W-1:0] mag_b;

    assign mag_a   = req.dividend[DATA_W-1] ? (~req.dividend + 1'b1) : req.dividend;
    assign mag_b   = req.divisor[DATA_W-1]  ? (~req.divisor + 1'b1)  : req.divisor;
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg    <= '0;
            quo_reg    <= mag_a;
            dvs_reg    <= mag_b;
            neg_q_reg  <= req.dividend[DATA_W-1] ^ req.divisor[DATA_W-1];
            neg_r_reg  <= req.dividend[DATA_W-1];
            is_mod_reg <= req.is_mod;
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_reg <= trial[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        if (is_mod_reg)
            rsp.result = neg_r_reg ? (~rem_reg + 1'b1) : rem_reg;
        else
            rsp.result = neg_q_reg ? (~quo_reg + 1'b1) : quo_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/integer_stack_machine_step.sv =====
// integer_stack_machine_step: executes one stack-machine instruction per transfer
// depends on ism_pkg, ism_in_if, ism_out_if and ism_div
//
//  channel   dir   payload                                               handshake
//  in_ch     in    mode, arg, index_address, input_value                 valid/ready
//  out_ch    out   next_pc, print_valid, print_value, halted, error      valid/ready
//  cfg       in    cfg_wr_data (start_address)                           cfg_wr_en
//
//  an instruction passes through idle, two memory read states, execute and write back;
//  div and mod also wait in the divide state for the bit-serial divider
//  after reset a pass clears all 1024 data memory words; no input is taken meanwhile
//  write back waits while a previous result is still held on out_ch
`default_nettype none

module integer_stack_machine_step
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ism_in_if.sink     in_ch,
    ism_out_if.source  out_ch,
    input  wire logic  cfg_wr_en,
    input  wire logic [11:0] cfg_wr_data
);
    import ism_pkg::*;

    state_t state_reg, state_next;

    // architectural state
    logic [SP_W-1:0]    sp_reg;
    logic [RSP_W-1:0]   rsp_reg;
    cmp_t               cmp_reg;
    logic [PC_W-1:0]    pc_reg;
    logic               halt_reg;
    logic               fresh_reg;
    logic [MEM_AW-1:0]  clr_cnt_reg;

    // captured instruction
    op_t                mode_reg;
    logic [DATA_W-1:0]  arg_reg;
    logic [DATA_W-1:0]  inval_reg;
    logic [DATA_W-1:0]  top_reg;
    logic [DATA_W-1:0]  sec_reg;
    logic [DATA_W-1:0]  memd_reg;
    logic [MEM_AW-1:0]  addr_reg;
    logic               addr_ok_reg;

    // write-back staging
    err_t               wb_err_reg;
    logic [PC_W-1:0]    wb_npc_reg;
    logic               wb_pv_reg;
    logic [DATA_W-1:0]  wb_pval_reg;
    logic               wb_halt_reg;
    logic [SP_W-1:0]    wb_sp_reg;
    logic [RSP_W-1:0]   wb_rsp_reg;
    cmp_t               wb_cmp_reg;
    logic               stk_we_reg;
    logic [STK_AW-1:0]  stk_wa_reg;
    logic [DATA_W-1:0]  res_reg;
    logic               mem_we_reg;
    logic               ret_we_reg;

    // output register
    logic               out_valid_reg;
    logic [PC_W-1:0]    out_npc_reg;
    logic               out_pv_reg;
    logic [DATA_W-1:0]  out_pval_reg;
    logic               out_halt_reg;
    err_t               out_err_reg;

    // memories
    logic [DATA_W-1:0]  stk_mem [STACK_DEPTH];
    logic [DATA_W-1:0]  data_mem [MEM_DEPTH];
    logic [PROG_AW-1:0] ret_mem [RET_DEPTH];
    logic [DATA_W-1:0]  stk_q;
    logic [DATA_W-1:0]  mem_q;
    logic [PROG_AW-1:0] ret_q;

    logic [STK_AW-1:0]  stk_ra;
    logic [MEM_AW-1:0]  mem_ra;
    logic               accept;
    logic               commit;
    logic               div_go;
    logic [SP_W-1:0]    sp_m1;
    logic [SP_W-1:0]    sp_m2;
    logic [RSP_W-1:0]   rsp_m1;
    logic [DATA_W:0]    addr_sum;
    logic [2*DATA_W-1:0] prod;

    div_req_t           div_req;
    div_rsp_t           div_rsp;

    // execute results
    err_t               ex_err;
    logic [PC_W-1:0]    ex_npc;
    logic               ex_pv;
    logic [SP_W-1:0]    ex_sp;
    logic [RSP_W-1:0]   ex_rsp;
    cmp_t               ex_cmp;
    logic               ex_stk_we;
    logic [STK_AW-1:0]  ex_stk_wa;
    logic [DATA_W-1:0]  ex_res;
    logic               ex_mem_we;
    logic               ex_ret_we;
    logic               ex_jump;
    logic               ex_div;
    logic               tgt_ok;

    assign sp_m1  = sp_reg - SP_W'(1);
    assign sp_m2  = sp_reg - SP_W'(2);
    assign rsp_m1 = rsp_reg - RSP_W'(1);
    assign addr_sum = {arg_reg[DATA_W-1], arg_reg}
                    + ((mode_reg == OP_STOREX || mode_reg == OP_LOADX)
                       ? {mem_q[DATA_W-1], mem_q} : '0);
    assign prod   = top_reg * sec_reg;
    assign tgt_ok = (arg_reg[DATA_W-1:PROG_AW] == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == MEM_AW'(MEM_DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (in_ch.valid) state_next = ST_READ1;
            ST_READ1: state_next = ST_READ2;
            ST_READ2: state_next = ST_EXEC;
            ST_EXEC:  state_next = (ex_div && !halt_reg && !pc_reg[PROG_AW]) ? ST_DIV : ST_WB;
            ST_DIV:   if (div_rsp.done) state_next = ST_WB;
            ST_WB:    if (!out_valid_reg || out_ch.ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ch.ready = (state_reg == ST_IDLE);
        accept      = in_ch.valid && (state_reg == ST_IDLE);
        commit      = (state_reg == ST_WB) && (!out_valid_reg || out_ch.ready);
        div_go      = (state_reg == ST_EXEC) && ex_div && !halt_reg && !pc_reg[PROG_AW];
        stk_ra      = (state_reg == ST_READ1) ? sp_m2[STK_AW-1:0] : sp_m1[STK_AW-1:0];
        mem_ra      = (state_reg == ST_READ1) ? addr_sum[MEM_AW-1:0] : in_ch.index_address;
    end

    // execute decode
    always_comb
    begin
        ex_err    = ERR_NONE;
        ex_npc    = pc_reg + PC_W'(1);
        ex_pv     = 1'b0;
        ex_sp     = sp_reg;
        ex_rsp    = rsp_reg;
        ex_cmp    = cmp_reg;
        ex_stk_we = 1'b0;
        ex_stk_wa = sp_reg[STK_AW-1:0];
        ex_res    = top_reg;
        ex_mem_we = 1'b0;
        ex_ret_we = 1'b0;
        ex_jump   = 1'b0;
        ex_div    = 1'b0;
        case (mode_reg)
            OP_NOP: ;
            OP_PUSH, OP_INPUT, OP_LOAD, OP_LOADX:
            begin
                if ((mode_reg == OP_LOAD || mode_reg == OP_LOADX) && !addr_ok_reg)
                    ex_err = ERR_BAD_ADDR;
                else if (sp_reg == SP_W'(STACK_DEPTH))
                    ex_err = ERR_OVERFLOW;
                else
                begin
                    ex_stk_we = 1'b1;
                    ex_sp     = sp_reg + SP_W'(1);
                    ex_res    = (mode_reg == OP_PUSH)  ? arg_reg :
                                (mode_reg == OP_INPUT) ? inval_reg : memd_reg;
                end
            end
            OP_PRINT:
            begin
                if (sp_reg == '0) ex_err = ERR_UNDERFLOW;
                else ex_pv = 1'b1;
            end
            OP_DECL:
            begin
                if (!addr_ok_reg) ex_err = ERR_BAD_ADDR;
            end
            OP_STORE, OP_STOREX:
            begin
                if (!addr_ok_reg) ex_err = ERR_BAD_ADDR;
                else if (sp_reg == '0) ex_err = ERR_UNDERFLOW;
                else
                begin
                    ex_mem_we = 1'b1;
                    ex_sp     = sp_m1;
                end
            end
            OP_CMP:
            begin
                if (sp_reg == '0) ex_err = ERR_UNDERFLOW;
                else if ($signed(top_reg) > $signed(arg_reg)) ex_cmp = CMP_GT;
                else if ($signed(top_reg) < $signed(arg_reg)) ex_cmp = CMP_LT;
                else ex_cmp = CMP_EQ;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD:
            begin
                if (sp_reg < SP_W'(2)) ex_err = ERR_UNDERFLOW;
                else if ((mode_reg == OP_DIV || mode_reg == OP_MOD) && sec_reg == '0)
                    ex_err = ERR_DIV_ZERO;
                else
                begin
                    ex_stk_we = 1'b1;
                    ex_stk_wa = sp_m2[STK_AW-1:0];
                    ex_sp     = sp_m1;
                    ex_div    = (mode_reg == OP_DIV || mode_reg == OP_MOD);
                    case (mode_reg)
                        OP_ADD:  ex_res = top_reg + sec_reg;
                        OP_SUB:  ex_res = top_reg - sec_reg;
                        OP_MUL:  ex_res = prod[DATA_W-1:0];
                        default: ex_res = top_reg;
                    endcase
                end
            end
            OP_POP:
            begin
                if (sp_reg == '0) ex_err = ERR_UNDERFLOW;
                else ex_sp = sp_m1;
            end
            OP_JMP: ex_jump = 1'b1;
            OP_JE:  ex_jump = (cmp_reg == CMP_EQ);
            OP_JNE: ex_jump = (cmp_reg != CMP_EQ);
            OP_JG:  ex_jump = (cmp_reg == CMP_GT);
            OP_JL:  ex_jump = (cmp_reg == CMP_LT);
            OP_JGE: ex_jump = (cmp_reg != CMP_LT);
            OP_JLE: ex_jump = (cmp_reg != CMP_GT);
            OP_CALL:
            begin
                if (!tgt_ok) ex_err = ERR_BAD_ADDR;
                else if (rsp_reg == RSP_W'(RET_DEPTH)) ex_err = ERR_OVERFLOW;
                else
                begin
                    ex_ret_we = 1'b1;
                    ex_rsp    = rsp_reg + RSP_W'(1);
                    ex_npc    = {1'b0, arg_reg[PROG_AW-1:0]};
                end
            end
            OP_RET:
            begin
                if (rsp_reg == '0) ex_err = ERR_UNDERFLOW;
                else
                begin
                    ex_rsp = rsp_m1;
                    ex_npc = {1'b0, ret_q};
                end
            end
            OP_EXIT: ex_npc = PC_W'(PROG_DEPTH);
            default: ex_err = ERR_BAD_OP;
        endcase
        if (ex_jump)
        begin
            if (!tgt_ok) ex_err = ERR_BAD_ADDR;
            else ex_npc = {1'b0, arg_reg[PROG_AW-1:0]};
        end
    end

    assign div_req.start    = div_go;
    assign div_req.is_mod   = (mode_reg == OP_MOD);
    assign div_req.dividend = top_reg;
    assign div_req.divisor  = sec_reg;

    ism_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            sp_reg        <= '0;
            rsp_reg       <= '0;
            cmp_reg       <= CMP_EQ;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            fresh_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (accept)
                fresh_reg <= 1'b0;
            if (cfg_wr_en && fresh_reg)
                pc_reg <= {1'b0, cfg_wr_data};
            if (commit)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            if (commit)
            begin
                sp_reg        <= wb_sp_reg;
                rsp_reg       <= wb_rsp_reg;
                cmp_reg       <= wb_cmp_reg;
                pc_reg        <= wb_npc_reg;
                halt_reg      <= wb_halt_reg;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= op_t'(in_ch.mode);
            arg_reg   <= in_ch.arg;
            inval_reg <= in_ch.input_value;
        end
        if (state_reg == ST_READ1)
        begin
            top_reg     <= stk_q;
            addr_reg    <= addr_sum[MEM_AW-1:0];
            addr_ok_reg <= (addr_sum[DATA_W:MEM_AW] == '0);
        end
        if (state_reg == ST_READ2)
        begin
            sec_reg  <= stk_q;
            memd_reg <= mem_q;
        end
        if (state_reg == ST_EXEC)
        begin
            if (halt_reg || pc_reg[PROG_AW])
            begin
                wb_err_reg  <= ERR_NONE;
                wb_npc_reg  <= pc_reg;
                wb_pv_reg   <= 1'b0;
                wb_halt_reg <= 1'b1;
                wb_sp_reg   <= sp_reg;
                wb_rsp_reg  <= rsp_reg;
                wb_cmp_reg  <= cmp_reg;
                stk_we_reg  <= 1'b0;
                mem_we_reg  <= 1'b0;
                ret_we_reg  <= 1'b0;
            end
            else if (ex_err != ERR_NONE && ex_err != ERR_BAD_OP)
            begin
                wb_err_reg  <= ex_err;
                wb_npc_reg  <= pc_reg;
                wb_pv_reg   <= 1'b0;
                wb_halt_reg <= 1'b0;
                wb_sp_reg   <= sp_reg;
                wb_rsp_reg  <= rsp_reg;
                wb_cmp_reg  <= cmp_reg;
                stk_we_reg  <= 1'b0;
                mem_we_reg  <= 1'b0;
                ret_we_reg  <= 1'b0;
            end
            else
            begin
                wb_err_reg  <= ex_err;
                wb_npc_reg  <= ex_npc;
                wb_pv_reg   <= ex_pv;
                wb_halt_reg <= ex_npc[PROG_AW];
                wb_sp_reg   <= ex_sp;
                wb_rsp_reg  <= ex_rsp;
                wb_cmp_reg  <= ex_cmp;
                stk_we_reg  <= ex_stk_we;
                mem_we_reg  <= ex_mem_we;
                ret_we_reg  <= ex_ret_we;
            end
            wb_pval_reg <= top_reg;
            stk_wa_reg  <= ex_stk_wa;
            res_reg     <= ex_res;
        end
        if (state_reg == ST_DIV && div_rsp.done)
            res_reg <= div_rsp.result;
        if (commit)
        begin
            out_npc_reg  <= wb_npc_reg;
            out_pv_reg   <= wb_pv_reg;
            out_pval_reg <= wb_pv_reg ? wb_pval_reg : '0;
            out_halt_reg <= wb_halt_reg;
            out_err_reg  <= wb_err_reg;
        end
    end

    // operand stack
    always_ff @(posedge clk)
    begin
        if (commit && stk_we_reg)
            stk_mem[stk_wa_reg] <= res_reg;
        stk_q <= stk_mem[stk_ra];
    end

    // data memory, cleared after reset
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            data_mem[clr_cnt_reg] <= '0;
        else if (commit && mem_we_reg)
            data_mem[addr_reg] <= top_reg;
        mem_q <= data_mem[mem_ra];
    end

    // return stack
    always_ff @(posedge clk)
    begin
        if (commit && ret_we_reg)
            ret_mem[rsp_reg[RET_AW-1:0]] <= PROG_AW'(pc_reg + PC_W'(1));
        ret_q <= ret_mem[rsp_m1[RET_AW-1:0]];
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.next_pc     = out_npc_reg;
    assign out_ch.print_valid = out_pv_reg;
    assign out_ch.print_value = out_pval_reg;
    assign out_ch.halted      = out_halt_reg;
    assign out_ch.error       = out_err_reg;

    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("operand stack pointer out of range");

    a_rsp_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_reg <= RSP_W'(RET_DEPTH))
        else $error("return stack pointer out of range");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared");

    a_wb_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB && out_valid_reg && !out_ch.ready) |=>
            ($stable(sp_reg) && $stable(pc_reg) && state_reg == ST_WB))
        else $error("write back while result pending");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !accept)
        else $error("transfer during memory clear");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// testbench: random and directed checking of integer_stack_machine_step
// depends on ism_pkg, ism_in_if, ism_out_if and the rtl top level
`timescale 1ns / 1ps

module testbench;
    import ism_pkg::*;

    typedef struct {
        logic [12:0] next_pc;
        logic        print_valid;
        logic [31:0] print_value;
        logic        halted;
        logic [2:0]  error;
    } step_res_t;

    typedef struct {
        logic [4:0]  mode;
        logic [31:0] arg;
        logic [9:0]  idx;
        logic [31:0] inval;
        bit          typed;
        logic [2:0]  err;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [11:0] cfg_wr_data = '0;

    ism_in_if  in_ch ();
    ism_out_if out_ch ();

    integer_stack_machine_step i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // machine state as predicted
    logic [31:0] opnd_stk [STACK_DEPTH];
    int          opnd_sp;
    logic [31:0] dmem [MEM_DEPTH];
    logic [11:0] call_stk [RET_DEPTH];
    int          call_sp;
    logic [1:0]  cmp_flag;
    int          pc_q;
    bit          halt_q;
    bit          fresh_q;

    step_res_t pending_steps [$];
    int        errors = 0;
    int        sent = 0;
    int        in_idle = 0;
    int        out_idle = 0;
    int        quiet_cycles = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.mode = '0;
        in_ch.arg = '0;
        in_ch.index_address = '0;
        in_ch.input_value = '0;
        out_ch.ready = 1'b0;
    end

    function automatic bit mem_ok(longint a);
        return a >= 0 && a < MEM_DEPTH;
    endfunction

    function automatic longint sx(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic step_res_t exec_instr(logic [4:0] mode, logic [31:0] arg,
                                             logic [9:0] idx, logic [31:0] inval);
        step_res_t r;
        longint    sarg;
        longint    addr;
        longint    sa;
        longint    sb;
        int        npc;
        logic [2:0] err;
        bit        jump;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] res;
        sarg = sx(arg);
        addr = sarg;
        npc = pc_q + 1;
        err = ERR_NONE;
        jump = 0;
        r.print_valid = 0;
        r.print_value = '0;
        fresh_q = 0;
        if (!halt_q && pc_q >= PROG_DEPTH)
            halt_q = 1;
        if (halt_q)
        begin
            r.next_pc = pc_q[12:0];
            r.halted = 1;
            r.error = ERR_NONE;
            return r;
        end
        case (mode)
            OP_NOP: ;
            OP_PUSH, OP_LOAD, OP_LOADX, OP_INPUT:
            begin
                if (mode == OP_LOADX)
                    addr = sarg + sx(dmem[idx]);
                if ((mode == OP_LOAD || mode == OP_LOADX) && !mem_ok(addr))
                    err = ERR_BAD_ADDR;
                else if (opnd_sp >= STACK_DEPTH)
                    err = ERR_OVERFLOW;
                else
                begin
                    opnd_stk[opnd_sp] = mode == OP_PUSH ? arg :
                                        mode == OP_INPUT ? inval : dmem[addr];
                    opnd_sp++;
                end
            end
            OP_PRINT:
                if (opnd_sp == 0)
                    err = ERR_UNDERFLOW;
                else
                begin
                    r.print_valid = 1;
                    r.print_value = opnd_stk[opnd_sp - 1];
                end
            OP_DECL:
                if (!mem_ok(sarg))
                    err = ERR_BAD_ADDR;
            OP_STORE, OP_STOREX:
            begin
                if (mode == OP_STOREX)
                    addr = sarg + sx(dmem[idx]);
                if (!mem_ok(addr))
                    err = ERR_BAD_ADDR;
                else if (opnd_sp == 0)
                    err = ERR_UNDERFLOW;
                else
                begin
                    opnd_sp--;
                    dmem[addr] = opnd_stk[opnd_sp];
                end
            end
            OP_CMP:
                if (opnd_sp == 0)
                    err = ERR_UNDERFLOW;
                else
                begin
                    sa = sx(opnd_stk[opnd_sp - 1]);
                    cmp_flag = sa > sarg ? CMP_GT : (sa < sarg ? CMP_LT : CMP_EQ);
                end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD:
                if (opnd_sp < 2)
                    err = ERR_UNDERFLOW;
                else
                begin
                    a = opnd_stk[opnd_sp - 1];
                    b = opnd_stk[opnd_sp - 2];
                    sa = sx(a);
                    sb = sx(b);
                    if ((mode == OP_DIV || mode == OP_MOD) && sb == 0)
                        err = ERR_DIV_ZERO;
                    else
                    begin
                        case (mode)
                            OP_ADD: res = a + b;
                            OP_SUB: res = a - b;
                            OP_MUL: res = a * b;
                            OP_DIV: res = 32'(sa / sb);
                            default: res = 32'(sa % sb);
                        endcase
                        opnd_sp--;
                        opnd_stk[opnd_sp - 1] = res;
                    end
                end
            OP_POP:
                if (opnd_sp == 0)
                    err = ERR_UNDERFLOW;
                else
                    opnd_sp--;
            OP_JMP: jump = 1;
            OP_JE:  jump = cmp_flag == CMP_EQ;
            OP_JNE: jump = cmp_flag != CMP_EQ;
            OP_JG:  jump = cmp_flag == CMP_GT;
            OP_JL:  jump = cmp_flag == CMP_LT;
            OP_JGE: jump = cmp_flag != CMP_LT;
            OP_JLE: jump = cmp_flag != CMP_GT;
            OP_CALL:
                if (sarg < 0 || sarg >= PROG_DEPTH)
                    err = ERR_BAD_ADDR;
                else if (call_sp >= RET_DEPTH)
                    err = ERR_OVERFLOW;
                else
                begin
                    call_stk[call_sp] = 12'(pc_q + 1);
                    call_sp++;
                    npc = int'(sarg);
                end
            OP_RET:
                if (call_sp == 0)
                    err = ERR_UNDERFLOW;
                else
                begin
                    call_sp--;
                    npc = call_stk[call_sp];
                end
            OP_EXIT: npc = PROG_DEPTH;
            default: err = ERR_BAD_OP;
        endcase
        if (jump)
        begin
            if (sarg < 0 || sarg >= PROG_DEPTH)
                err = ERR_BAD_ADDR;
            else
                npc = int'(sarg);
        end
        if (err != ERR_NONE && err != ERR_BAD_OP)
        begin
            npc = pc_q;
            r.print_valid = 0;
            r.print_value = '0;
        end
        else
        begin
            pc_q = npc;
            if (npc >= PROG_DEPTH)
                halt_q = 1;
        end
        r.next_pc = npc[12:0];
        r.halted = halt_q;
        r.error = err;
        return r;
    endfunction

    task automatic write_start(logic [11:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        if (fresh_q)
            pc_q = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send(logic [4:0] mode, logic [31:0] arg, logic [9:0] idx,
                        logic [31:0] inval, bit typed, logic [2:0] typed_err);
        step_res_t r;
        while ($urandom_range(0, 99) < in_idle)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.mode <= mode;
        in_ch.arg <= arg;
        in_ch.index_address <= idx;
        in_ch.input_value <= inval;
        do
            @(posedge clk);
        while (!in_ch.ready);
        r = exec_instr(mode, arg, idx, inval);
        if (typed)
            r.error = typed_err;
        pending_steps = {pending_steps, r};
        sent++;
        @(negedge clk);
    endtask

    task automatic op(logic [4:0] mode, logic [31:0] arg);
        send(mode, arg, 10'($urandom), $urandom, 0, ERR_NONE);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_steps.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 3) - 1;
            3: return $urandom_range(0, 1023);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return 32'd1024;
            2: return 32'hffffffff;
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    function automatic logic [31:0] pick_target();
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return 32'd4096;
            default: return $urandom_range(0, 3000);
        endcase
    endfunction

    task automatic random_sequence();
        int n;
        if (pc_q > 3800)
        begin
            op(OP_JMP, $urandom_range(0, 2000));
            return;
        end
        case ($urandom_range(0, 19))
            0, 1, 2:
            begin
                n = $urandom_range(0, 31);
                if (n == OP_EXIT)
                    n = OP_NOP;
                if (n >= OP_JMP && n <= OP_CALL)
                    op(5'(n), pick_target());
                else if (n == OP_CMP || n == OP_PUSH)
                    op(5'(n), pick_value());
                else
                    op(5'(n), pick_addr());
            end
            3, 4, 5, 6:
            begin
                op(OP_PUSH, $urandom_range(0, 3) == 0 ? 32'd0 : pick_value());
                op(OP_INPUT, 'x === 1'b0 ? 0 : $urandom);
                op(5'($urandom_range(OP_ADD, OP_MOD)), $urandom);
                if ($urandom_range(0, 1))
                    op(OP_PRINT, $urandom);
            end
            7, 8, 9, 10:
            begin
                op(OP_PUSH, $urandom_range(0, 1) ? $urandom_range(0, 600) : pick_value());
                n = $urandom_range(0, 1023);
                op(OP_STORE, n);
                op(OP_PUSH, $urandom_range(0, 1) ? $urandom_range(0, 400) : $urandom);
                send(OP_STOREX, $urandom_range(0, 400), n[9:0], $urandom, 0, ERR_NONE);
                send(OP_LOADX, $urandom_range(0, 1) ? $urandom_range(0, 400) : pick_addr(),
                     n[9:0], $urandom, 0, ERR_NONE);
                op(OP_LOAD, pick_addr());
                op(OP_PRINT, $urandom);
            end
            11, 12, 13, 14:
            begin
                if (opnd_sp == 0)
                    op(OP_PUSH, pick_value());
                op(OP_CMP, $urandom_range(0, 1) ? opnd_stk[opnd_sp - 1] : pick_value());
                op(5'($urandom_range(OP_JE, OP_JLE)), pick_target());
            end
            15, 16:
            begin
                op(OP_CALL, pick_target());
                op(OP_DECL, pick_addr());
                if ($urandom_range(0, 1))
                    op(OP_RET, $urandom);
            end
            17:
            begin
                while (opnd_sp < STACK_DEPTH)
                    op($urandom_range(0, 1) ? OP_PUSH : OP_INPUT, $urandom);
                op(OP_PUSH, $urandom);
                n = $urandom_range(1, STACK_DEPTH);
                repeat (n) op(OP_POP, $urandom);
            end
            18:
            begin
                while (call_sp < RET_DEPTH)
                    op(OP_CALL, $urandom_range(0, 3000));
                op(OP_CALL, $urandom_range(0, 3000));
                n = $urandom_range(1, RET_DEPTH);
                repeat (n) op(OP_RET, $urandom);
            end
            default:
                while (opnd_sp > 0)
                    op(OP_POP, $urandom);
        endcase
    endtask

    stim_row_t directed [] = '{
        '{OP_PRINT, 0, 0, 0, 1, ERR_UNDERFLOW},
        '{OP_POP,   0, 0, 0, 1, ERR_UNDERFLOW},
        '{OP_RET,   0, 0, 0, 1, ERR_UNDERFLOW},
        '{OP_ADD,   0, 0, 0, 1, ERR_UNDERFLOW},
        '{OP_PUSH,  32'h7fffffff, 10'h3ff, 32'hffffffff, 0, ERR_NONE},
        '{OP_PUSH,  32'h80000000, 0, 0, 0, ERR_NONE},
        '{OP_PRINT, 0, 0, 0, 0, ERR_NONE},
        '{OP_ADD,   0, 0, 0, 0, ERR_NONE},
        '{OP_PUSH,  0, 0, 0, 0, ERR_NONE},
        '{OP_PUSH,  5, 0, 0, 0, ERR_NONE},
        '{OP_DIV,   0, 0, 0, 1, ERR_DIV_ZERO},
        '{OP_MOD,   0, 0, 0, 1, ERR_DIV_ZERO},
        '{OP_POP,   0, 0, 0, 0, ERR_NONE},
        '{OP_PUSH,  32'hffffffff, 0, 0, 0, ERR_NONE},
        '{OP_INPUT, 0, 0, 32'h80000000, 0, ERR_NONE},
        '{OP_DIV,   0, 0, 0, 0, ERR_NONE},
        '{OP_LOAD,  1024, 0, 0, 1, ERR_BAD_ADDR},
        '{OP_LOAD,  32'hffffffff, 0, 0, 1, ERR_BAD_ADDR},
        '{OP_DECL,  1023, 0, 0, 0, ERR_NONE},
        '{OP_STORE, 1023, 0, 0, 0, ERR_NONE},
        '{OP_JMP,   4096, 0, 0, 1, ERR_BAD_ADDR},
        '{OP_CALL,  32'h80000000, 0, 0, 1, ERR_BAD_ADDR},
        '{5'd31,    0, 0, 0, 1, ERR_BAD_OP},
        '{OP_CMP,   0, 0, 0, 0, ERR_NONE},
        '{OP_CALL,  0, 0, 0, 0, ERR_NONE}
    };

    always @(negedge clk)
        out_ch.ready <= $urandom_range(0, 99) >= out_idle;

    always @(posedge clk)
    begin
        step_res_t e;
        if (out_ch.valid && out_ch.ready)
        begin
            if (pending_steps.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result transfer: pc %0d err %0d",
                             out_ch.next_pc, out_ch.error);
            end
            else
            begin
                e = pending_steps.pop_front();
                if (out_ch.next_pc !== e.next_pc || out_ch.print_valid !== e.print_valid
                    || out_ch.print_value !== e.print_value || out_ch.halted !== e.halted
                    || out_ch.error !== e.error)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp pc %0d pv %0d val %h halt %0d err %0d, got pc %0d pv %0d val %h halt %0d err %0d",
                                 e.next_pc, e.print_valid, e.print_value, e.halted, e.error,
                                 out_ch.next_pc, out_ch.print_valid, out_ch.print_value,
                                 out_ch.halted, out_ch.error);
                end
            end
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= 5000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        foreach (opnd_stk[i]) opnd_stk[i] = '0;
        foreach (dmem[i]) dmem[i] = '0;
        foreach (call_stk[i]) call_stk[i] = '0;
        opnd_sp = 0;
        call_sp = 0;
        cmp_flag = CMP_EQ;
        pc_q = 0;
        halt_q = 0;
        fresh_q = 1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        write_start(12'hfff);
        write_start(12'h000);
        write_start(12'd100);
        in_idle = 21;
        out_idle = 76;
        foreach (directed[i])
            send(directed[i].mode, directed[i].arg, directed[i].idx, directed[i].inval,
                 directed[i].typed, directed[i].err);
        while (sent < 270)
            random_sequence();
        drain();
        write_start(12'haaa);
        in_idle = 76;
        out_idle = 21;
        while (sent < 520)
            random_sequence();
        drain();
        write_start(12'h555);
        in_idle = 0;
        out_idle = 0;
        while (sent < 770)
            random_sequence();
        op(OP_EXIT, $urandom);
        op(OP_PUSH, $urandom);
        op(OP_NOP, $urandom);
        in_ch.valid <= 1'b0;
        while (pending_steps.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
